/* rtl/core/chrt_pkg.sv */
package chrt_pkg;

   localparam int DefNumBuckets = 16;
   localparam int DefNumNodes   = 64;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;
   localparam logic [1:0] ACT_LOOKUP = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam int KeyW   = 40;
   localparam int DatesW = 48;
   localparam int RouteW = 34;
   localparam int ReqW   = 128;
   localparam int RspW   = 96;

endpackage

/* rtl/core/chrt_ram.sv */
module chrt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/core/chained_hash_record_table_top.sv */
// Record table keyed by (passenger_id, flight_number), chained hash over
// NUM_BUCKETS buckets with a pool of NUM_NODES nodes. One beat is taken at a
// time; req_tready is low until its response beat is taken. After reset a
// clearing pass marks every node free, with req_tready low. Per item, after
// the accepting cycle: extraction of each decimal digit of the flight number
// (1-5); hashing of each digit in S_HASH, S_MODQ and S_MODR (multiply-add,
// reciprocal quotient, remainder); then for insert a scan of free-pool entries
// up to the lowest free node (all NUM_NODES when full), or for the other
// actions a read and a compare per chain node visited plus one more read on a
// miss; then a write-back and a response, held while rsp_tready is low. Node
// storage and the free flags are in RAMs with registered read; heads, tails
// and counts are flops.
module chained_hash_record_table_top #(
   parameter int NUM_BUCKETS = chrt_pkg::DefNumBuckets,
   parameter int NUM_NODES   = chrt_pkg::DefNumNodes
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // action, passenger_id, flight_number, flight_date, origin_code,
   // destination_code, seat_class, booked_date, cancel_date; zero pad
   input  logic [chrt_pkg::ReqW-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status, bucket_index, chain_length, found_flight_date, found_origin,
   // found_destination, found_seat_class, found_booked_date,
   // found_cancel_date; zero pad
   output logic [chrt_pkg::RspW-1:0] rsp_tdata
);
   import chrt_pkg::*;

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int NW = $clog2(NUM_NODES);
   localparam int PW = NW + 1;  // node pointer incl. end marker
   localparam logic [PW-1:0] EndMark = PW'(NUM_NODES);
   localparam int MW = BW + 14;
   localparam logic [MW-1:0] NumB  = MW'(NUM_BUCKETS);
   localparam logic [MW-1:0] Recip = MW'((64'd1 << MW) / 64'(NUM_BUCKETS));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIGIT = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_WB    = 4'd6;
   localparam logic [3:0] S_RSP   = 4'd7;
   localparam logic [3:0] S_MODQ  = 4'd8;
   localparam logic [3:0] S_MODR  = 4'd9;
   localparam logic [3:0] S_CLEAR = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;

   logic [1:0]   act_ff;
   logic [KeyW-1:0]   key_ff;
   logic [DatesW-1:0] dates_ff;
   logic [RouteW-1:0] route_ff;

   // digit extraction
   logic [15:0] v_ff, v_in;
   logic [3:0]  dig_ff [5];
   logic [2:0]  ndig_ff, ndig_in;
   logic [BW-1:0] h_ff, h_in;

   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [NW:0]   steps_ff, steps_in;

   logic [PW-1:0] head_ff [NUM_BUCKETS];
   logic [PW-1:0] tail_ff [NUM_BUCKETS];
   logic [PW-1:0] cnt_ff  [NUM_BUCKETS];
   logic [PW-1:0] cnt_new;

   logic [1:0] status_ff;
   logic [6:0] len_ff;
   logic [DatesW-1:0] fdates_ff;
   logic [RouteW-1:0] froute_ff;
   logic rsp_valid_ff;

   // lowest free node
   logic [PW-1:0] scan_ff, scan_in;

   // RAM ports
   logic [NW-1:0] rd_addr;
   logic [KeyW-1:0] rd_key;
   logic [DatesW-1:0] rd_dates;
   logic [RouteW-1:0] rd_route;
   logic [PW-1:0] rd_link;
   logic data_we, link_we, key_we;
   logic [NW-1:0] data_wa, link_wa;
   logic [PW-1:0] link_wd;
   logic free_we, free_wd, rd_free;
   logic [NW-1:0] free_wa, free_ra;

   // read address follows the next pointer so data lines up with cur_ff
   assign rd_addr = cur_in[NW-1:0];
   assign free_ra = scan_in[NW-1:0];

   chrt_ram #(.Width(KeyW), .Depth(NUM_NODES)) u_key (
      .clock, .wr_en(key_we), .wr_addr(data_wa), .wr_data(key_ff),
      .rd_addr, .rd_data(rd_key));
   chrt_ram #(.Width(DatesW), .Depth(NUM_NODES)) u_dates (
      .clock, .wr_en(data_we), .wr_addr(data_wa), .wr_data(dates_ff),
      .rd_addr, .rd_data(rd_dates));
   chrt_ram #(.Width(RouteW), .Depth(NUM_NODES)) u_route (
      .clock, .wr_en(data_we), .wr_addr(data_wa), .wr_data(route_ff),
      .rd_addr, .rd_data(rd_route));
   chrt_ram #(.Width(PW), .Depth(NUM_NODES)) u_link (
      .clock, .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr, .rd_data(rd_link));
   chrt_ram #(.Width(1), .Depth(NUM_NODES)) u_free (
      .clock, .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(rd_free));

   // divide by 10 through a reciprocal multiply, exact for 16-bit values
   logic [31:0] dprod;
   logic [15:0] vq, vrem;
   assign dprod = 32'(v_ff) * 32'd52429;
   assign vq    = 16'(dprod[31:19]);
   assign vrem  = v_ff - ((vq << 3) + (vq << 1));

   // hash step: h*127 + ascii, reduced by NUM_BUCKETS via a reciprocal
   // quotient that is at most one low, then one correcting subtract
   logic [3:0]  cur_digit;
   logic [MW-1:0] mac, mac_ff, q_ff, rem0;
   logic [2*MW-1:0] qprod;
   logic [BW-1:0] mac_mod;
   assign cur_digit = dig_ff[ndig_ff - 3'd1];
   assign mac = MW'(h_ff) * MW'(127) + MW'(48 + cur_digit);
   assign qprod = (2*MW)'(mac_ff) * (2*MW)'(Recip);
   assign rem0 = mac_ff - q_ff * NumB;
   assign mac_mod = (rem0 >= NumB) ? BW'(rem0 - NumB) : BW'(rem0);

   logic [BW-1:0] b;
   assign b = h_ff;
   logic accept;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      v_in = v_ff;
      ndig_in = ndig_ff;
      h_in = h_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      scan_in = scan_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(NUM_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               v_in = req_tdata[41:26];
               ndig_in = '0;
               h_in = '0;
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            v_in = vq;
            ndig_in = ndig_ff + 3'd1;
            if (v_ff < 16'd10 || ndig_ff == 3'd4) begin
               state_in = S_HASH;
            end
         end
         S_HASH: state_in = S_MODQ;
         S_MODQ: state_in = S_MODR;
         S_MODR: begin
            h_in = mac_mod;
            ndig_in = ndig_ff - 3'd1;
            if (ndig_ff == 3'd1) begin
               steps_in = '0;
               if (act_ff == ACT_INSERT) begin
                  scan_in = '0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               state_in = S_HASH;
            end
         end
         S_SCAN: begin
            if (rd_free || scan_ff == PW'(NUM_NODES - 1)) begin
               state_in = S_WB;
            end else begin
               scan_in = scan_ff + PW'(1);
            end
         end
         S_READ: begin
            if (steps_ff == '0) begin
               cur_in = head_ff[b];
               prev_in = EndMark;
            end
            if ((steps_ff == '0 ? head_ff[b] : cur_ff) == EndMark ||
                steps_ff == (NW+1)'(NUM_NODES)) begin
               cur_in = EndMark;
               state_in = S_WB;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_key == key_ff) begin
               state_in = S_WB;
            end else begin
               prev_in = cur_ff;
               cur_in = rd_link;
               steps_in = steps_ff + (NW+1)'(1);
               state_in = S_READ;
            end
         end
         S_WB: state_in = S_RSP;
         S_RSP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // write-back decisions
   logic found, ins_ok;
   assign found  = (cur_ff != EndMark);
   assign ins_ok = rd_free;

   assign cnt_new = (act_ff == ACT_INSERT && ins_ok) ? cnt_ff[b] + PW'(1) :
                    (act_ff == ACT_DELETE && found && cnt_ff[b] != '0) ?
                    cnt_ff[b] - PW'(1) : cnt_ff[b];

   always_comb begin
      key_we = 1'b0;
      data_we = 1'b0;
      link_we = 1'b0;
      data_wa = scan_ff[NW-1:0];
      link_wa = scan_ff[NW-1:0];
      link_wd = EndMark;
      free_we = 1'b0;
      free_wa = clr_ff;
      free_wd = 1'b1;
      if (state_ff == S_CLEAR) begin
         free_we = 1'b1;
      end else if (state_ff == S_SCAN && state_in == S_WB && ins_ok) begin
         // new node: fill it, link := end
         key_we = 1'b1;
         data_we = 1'b1;
         link_we = 1'b1;
      end else if (state_ff == S_WB) begin
         if (act_ff == ACT_INSERT) begin
            link_we = ins_ok && tail_ff[b] != EndMark;
            link_wa = tail_ff[b][NW-1:0];
            link_wd = scan_ff;
            free_we = ins_ok;
            free_wa = scan_ff[NW-1:0];
            free_wd = 1'b0;
         end else if (act_ff == ACT_DELETE) begin
            link_we = found && prev_ff != EndMark;
            link_wa = prev_ff[NW-1:0];
            link_wd = rd_link;
            free_we = found;
            free_wa = cur_ff[NW-1:0];
            free_wd = 1'b1;
         end else if (act_ff == ACT_UPDATE) begin
            data_we = found;
            data_wa = cur_ff[NW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            head_ff[i] <= EndMark;
            tail_ff[i] <= EndMark;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (state_ff == S_WB) rsp_valid_ff <= 1'b1;
         else if (state_ff == S_RSP && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_WB) begin
            cnt_ff[b] <= cnt_new;
            if (act_ff == ACT_INSERT && ins_ok) begin
               if (tail_ff[b] == EndMark) head_ff[b] <= scan_ff;
               tail_ff[b] <= scan_ff;
            end else if (act_ff == ACT_DELETE && found) begin
               if (prev_ff == EndMark) head_ff[b] <= rd_link;
               if (tail_ff[b] == cur_ff) tail_ff[b] <= prev_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      ndig_ff <= ndig_in;
      h_ff <= h_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      scan_ff <= scan_in;
      if (state_ff == S_DIGIT) dig_ff[ndig_ff] <= vrem[3:0];
      if (state_ff == S_HASH) mac_ff <= mac;
      if (state_ff == S_MODQ) q_ff <= qprod[2*MW-1:MW];
      if (accept) begin
         act_ff   <= req_tdata[1:0];
         key_ff   <= {req_tdata[25:2], req_tdata[41:26]};
         dates_ff <= {req_tdata[57:42], req_tdata[107:92], req_tdata[123:108]};
         route_ff <= {req_tdata[73:58], req_tdata[89:74], req_tdata[91:90]};
      end
      if (state_ff == S_WB) begin
         fdates_ff <= '0;
         froute_ff <= '0;
         len_ff <= (32'(cnt_new) > 32'd127) ? 7'd127 : 7'(cnt_new);
         if (act_ff == ACT_INSERT) begin
            status_ff <= ins_ok ? ST_DONE : ST_FULL;
         end else begin
            status_ff <= found ? ST_DONE : ST_NOTFOUND;
            if (act_ff == ACT_LOOKUP && found) begin
               fdates_ff <= rd_dates;
               froute_ff <= rd_route;
            end
         end
      end
   end

   logic [3:0] bidx;
   assign bidx = 4'(b);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, fdates_ff[15:0], fdates_ff[31:16], froute_ff[1:0],
                       froute_ff[17:2], froute_ff[33:18], fdates_ff[47:32],
                       len_ff, bidx, status_ff};

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while response pending");
   a_rsp_after_wb: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WB |=> rsp_tvalid) else $error("no response after write-back");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status_ff <= ST_FULL) else $error("bad status");
endmodule

/* bench/chrt_table_checker.sv */
module chrt_table_checker
   import chrt_pkg::*;
#(
   parameter int NUM_BUCKETS = DefNumBuckets,
   parameter int NUM_NODES   = DefNumNodes
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tready,
   input  logic [ReqW-1:0] req_tdata,
   input  logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  logic [RspW-1:0] rsp_tdata,
   output int              fail_count,
   output int              pending,
   output int              checked_count,
   output int              full_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  bucket;
      logic [6:0]  chain_len;
      logic [15:0] fdate;
      logic [15:0] origin;
      logic [15:0] dest;
      logic [1:0]  seat;
      logic [15:0] bdate;
      logic [15:0] cdate;
   } rsp_fields_type;

   typedef struct packed {
      logic [23:0] pid;
      logic [15:0] flight;
      logic [15:0] fdate;
      logic [15:0] origin;
      logic [15:0] dest;
      logic [1:0]  seat;
      logic [15:0] bdate;
      logic [15:0] cdate;
   } record_type;

   localparam int EndMark = NUM_NODES;

   int             head_q[NUM_BUCKETS];
   int             tail_q[NUM_BUCKETS];
   int             count_q[NUM_BUCKETS];
   record_type     rec_q[NUM_NODES];
   int             link_q[NUM_NODES];
   bit             free_q[NUM_NODES];
   rsp_fields_type expected_rsps[$];

   function automatic int flight_bucket(input logic [15:0] flight);
      int digit_buf[5];
      int n;
      int h;
      int v;
      n = 0;
      h = 0;
      v = flight;
      do begin
         digit_buf[n] = v % 10;
         v = v / 10;
         n++;
      end while (v != 0);
      while (n > 0) begin
         n--;
         h = (127 * h + 48 + digit_buf[n]) % NUM_BUCKETS;
      end
      return h;
   endfunction

   function automatic rsp_fields_type apply_request(input logic [ReqW-1:0] d);
      rsp_fields_type r;
      logic [1:0]     act;
      record_type     rec;
      int             b;
      int             cur;
      int             prv;
      int             node;
      int             steps;
      act = d[1:0];
      rec.pid    = d[25:2];
      rec.flight = d[41:26];
      rec.fdate  = d[57:42];
      rec.origin = d[73:58];
      rec.dest   = d[89:74];
      rec.seat   = d[91:90];
      rec.bdate  = d[107:92];
      rec.cdate  = d[123:108];
      b = flight_bucket(rec.flight);
      r = '0;
      r.status = ST_NOTFOUND;
      if (act == ACT_INSERT) begin
         node = EndMark;
         for (int i = NUM_NODES - 1; i >= 0; i--)
            if (free_q[i]) node = i;
         if (node == EndMark) begin
            r.status = ST_FULL;
         end else begin
            free_q[node] = 0;
            rec_q[node]  = rec;
            link_q[node] = EndMark;
            if (tail_q[b] != EndMark) link_q[tail_q[b]] = node;
            else head_q[b] = node;
            tail_q[b] = node;
            count_q[b]++;
            r.status = ST_DONE;
         end
      end else begin
         cur   = head_q[b];
         prv   = EndMark;
         node  = EndMark;
         steps = 0;
         while (cur != EndMark && steps < NUM_NODES && node == EndMark) begin
            if (rec_q[cur].pid == rec.pid && rec_q[cur].flight == rec.flight) begin
               node = cur;
            end else begin
               prv = cur;
               cur = link_q[cur];
               steps++;
            end
         end
         if (node != EndMark) begin
            r.status = ST_DONE;
            case (act)
               ACT_DELETE: begin
                  if (prv != EndMark) link_q[prv] = link_q[node];
                  else head_q[b] = link_q[node];
                  if (tail_q[b] == node) tail_q[b] = prv;
                  if (count_q[b] > 0) count_q[b]--;
                  free_q[node] = 1;
               end
               ACT_UPDATE: begin
                  rec.pid     = rec_q[node].pid;
                  rec.flight  = rec_q[node].flight;
                  rec_q[node] = rec;
               end
               default: begin
                  r.fdate  = rec_q[node].fdate;
                  r.origin = rec_q[node].origin;
                  r.dest   = rec_q[node].dest;
                  r.seat   = rec_q[node].seat;
                  r.bdate  = rec_q[node].bdate;
                  r.cdate  = rec_q[node].cdate;
               end
            endcase
         end
      end
      r.bucket    = b[3:0];
      r.chain_len = (count_q[b] > 127) ? 7'd127 : count_q[b][6:0];
      return r;
   endfunction

   function automatic rsp_fields_type unpack_rsp(input logic [RspW-1:0] d);
      rsp_fields_type r;
      r.status    = d[1:0];
      r.bucket    = d[5:2];
      r.chain_len = d[12:6];
      r.fdate     = d[28:13];
      r.origin    = d[44:29];
      r.dest      = d[60:45];
      r.seat      = d[62:61];
      r.bdate     = d[78:63];
      r.cdate     = d[94:79];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_fields_type exp_r;
      rsp_fields_type got;
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            head_q[i]  = EndMark;
            tail_q[i]  = EndMark;
            count_q[i] = 0;
         end
         for (int i = 0; i < NUM_NODES; i++) begin
            free_q[i] = 1;
            link_q[i] = EndMark;
            rec_q[i]  = '0;
         end
         expected_rsps.delete();
         fail_count    <= 0;
         checked_count <= 0;
         full_count    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            exp_r = apply_request(req_tdata);
            expected_rsps.push_back(exp_r);
            if (exp_r.status == ST_FULL) full_count <= full_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            checked_count <= checked_count + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got.status != exp_r.status || got.bucket != exp_r.bucket ||
                   got.chain_len != exp_r.chain_len || got.fdate != exp_r.fdate ||
                   got.origin != exp_r.origin || got.dest != exp_r.dest ||
                   got.seat != exp_r.seat || got.bdate != exp_r.bdate ||
                   got.cdate != exp_r.cdate) begin
                  $display("%0t: mismatch expected st=%0d bkt=%0d len=%0d pay=%h_%h_%h_%h_%h_%h",
                           $time, exp_r.status, exp_r.bucket, exp_r.chain_len,
                           exp_r.fdate, exp_r.origin, exp_r.dest, exp_r.seat,
                           exp_r.bdate, exp_r.cdate);
                  $display("%0t:          actual   st=%0d bkt=%0d len=%0d pay=%h_%h_%h_%h_%h_%h",
                           $time, got.status, got.bucket, got.chain_len,
                           got.fdate, got.origin, got.dest, got.seat,
                           got.bdate, got.cdate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_rsps.size();
   end

endmodule

/* bench/tb_chained_hash_record_table_top.sv */
module tb_chained_hash_record_table_top;
   import chrt_pkg::*;

   localparam int CycleLimit = 2000000;

   logic            clock = 0;
   logic            reset = 1;
   logic            req_tvalid = 0;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 0;
   logic [RspW-1:0] rsp_tdata;
   int              fail_count;
   int              pending;
   int              checked_count;
   int              full_count;
   int              cycle_count = 0;
   int              burst_left = 0;
   int              sent_count = 0;
   logic [23:0]     pid_pool[24];
   logic [15:0]     flight_pool[10];

   always #5 clock = ~clock;

   chained_hash_record_table_top u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   chrt_table_checker u_chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .pending, .checked_count, .full_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver backpressure: four modes, chosen by cycle_count[9:8]
   always @(posedge clock) begin
      case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_tready <= (cycle_count[4:0] > 5'd20);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic send_beat(input logic [1:0] act, input logic [23:0] pid,
                            input logic [15:0] flight, input logic [81:0] payload);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 30) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, payload, flight, pid, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   function automatic logic [81:0] rand_payload();
      return {$urandom(), $urandom(), 18'($urandom())};
   endfunction

   initial begin
      logic [1:0]  act;
      logic [23:0] pid;
      logic [15:0] flight;
      int          r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every action, duplicates, misses
      send_beat(ACT_INSERT, 24'h0, 16'h0, '0);
      send_beat(ACT_INSERT, 24'hFFFFFF, 16'hFFFF, '1);
      send_beat(ACT_LOOKUP, 24'h0, 16'h0, rand_payload());
      send_beat(ACT_LOOKUP, 24'hFFFFFF, 16'hFFFF, '0);
      send_beat(ACT_LOOKUP, 24'h1, 16'h0, '0);
      send_beat(ACT_UPDATE, 24'h0, 16'h0, '1);
      send_beat(ACT_LOOKUP, 24'h0, 16'h0, '0);
      send_beat(ACT_INSERT, 24'h0, 16'h0, rand_payload());
      send_beat(ACT_INSERT, 24'h5, 16'h10, rand_payload());
      send_beat(ACT_INSERT, 24'h5, 16'h9, rand_payload());
      send_beat(ACT_DELETE, 24'h0, 16'h0, '0);
      send_beat(ACT_LOOKUP, 24'h0, 16'h0, '0);
      send_beat(ACT_DELETE, 24'h0, 16'h0, '0);
      send_beat(ACT_DELETE, 24'h0, 16'h0, '0);
      send_beat(ACT_UPDATE, 24'h7, 16'h7, rand_payload());
      send_beat(ACT_UPDATE, 24'hFFFFFF, 16'hFFFF, '0);
      send_beat(ACT_LOOKUP, 24'hFFFFFF, 16'hFFFF, '0);
      send_beat(ACT_DELETE, 24'hFFFFFF, 16'hFFFF, '0);
      // fill the pool until it overflows
      for (int i = 0; i < 66; i++)
         send_beat(ACT_INSERT, 24'($urandom()), 16'($urandom_range(0, 20)), rand_payload());

      for (int i = 0; i < 24; i++) pid_pool[i] = 24'($urandom());
      pid_pool[0] = 24'h0;
      pid_pool[1] = 24'hFFFFFF;
      for (int i = 0; i < 10; i++) flight_pool[i] = 16'($urandom());
      flight_pool[0] = 16'h0;
      flight_pool[1] = 16'hFFFF;
      flight_pool[2] = 16'd9;
      flight_pool[3] = 16'd10;

      // random: reused keys, alternating fill and drain phases
      for (int i = 0; i < 1200; i++) begin
         r = $urandom_range(0, 99);
         if (((i / 150) % 2) == 0) act = (r < 55) ? ACT_INSERT : 2'($urandom_range(1, 3));
         else act = (r < 15) ? ACT_INSERT : ((r < 60) ? ACT_DELETE : 2'($urandom_range(2, 3)));
         if ($urandom_range(0, 9) == 0) begin
            pid    = 24'($urandom());
            flight = 16'($urandom());
         end else begin
            pid    = pid_pool[$urandom_range(0, 23)];
            flight = flight_pool[$urandom_range(0, 9)];
         end
         send_beat(act, pid, flight, rand_payload());
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d pool-full inserts",
               sent_count, checked_count, full_count);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
